### rtl/core/frp_pkg.sv
// Shared types, constants and helper function of the framed packet receiver.
package frp_pkg;

  localparam int TYPE_BYTES = 8;
  localparam int BODY_BYTES = 64;
  localparam int TYPE_SLOTS = 4;

  localparam int TYPE_AW = $clog2(TYPE_BYTES);
  localparam int TYPE_CW = $clog2(TYPE_BYTES + 1);
  localparam int BODY_AW = $clog2(BODY_BYTES);
  localparam int BODY_CW = $clog2(BODY_BYTES + 1);
  localparam int SLOT_W  = 2;
  localparam int LEN_W   = 6;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 64;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_SEP   = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [15:0] RESET_TIMEOUT = 16'd3000;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IW-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TIMEOUT  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SLOTS    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_PATTERN0 = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PATTERN1 = 3'd4;
  localparam logic [CFG_IW-1:0] REG_PATTERN2 = 3'd5;
  localparam logic [CFG_IW-1:0] REG_PATTERN3 = 3'd6;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TYPE = 2'd1;
  localparam logic [1:0] MODE_BODY = 2'd2;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_NO_TYPE  = 2'd3;

  typedef struct packed {
    logic              start;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } job_t;

  typedef struct packed {
    logic               en;
    logic [BODY_AW-1:0] addr;
    logic [7:0]         data;
  } ram_wr_t;

  // Returns {digit_ok, value} for one ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    begin
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
        r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
    end
  endfunction

endpackage

### rtl/core/frp_body_ram.sv
// Body byte store: one write port and one registered read port.
module frp_body_ram (
  input  logic                         clk,
  input  frp_pkg::ram_wr_t             wr,
  input  logic                         rd_en,
  input  logic [frp_pkg::BODY_AW-1:0]  rd_addr,
  output logic [7:0]                   rd_data
);

  logic [7:0] mem [frp_pkg::BODY_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/frp_parser.sv
// Frame parser: configuration registers, mode, timeout, checksum and type matching.
module frp_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [frp_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [frp_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          item_take,
  input  logic                          command,
  input  logic [7:0]                    rx_byte,
  output frp_pkg::ram_wr_t              ram_wr,
  output frp_pkg::job_t                 job
);

  logic        receive_enable;
  logic [15:0] timeout_ticks;
  logic [2:0]  type_slots_used;
  logic [63:0] type_pattern [frp_pkg::TYPE_SLOTS];

  logic [1:0]                 mode;
  logic [1:0]                 mode_next;
  logic [7:0]                 type_store [frp_pkg::TYPE_BYTES];
  logic [frp_pkg::TYPE_CW-1:0] type_count;
  logic [7:0]                 type_xor;
  logic                       type_ended;
  logic [frp_pkg::BODY_CW-1:0] body_count;
  logic [7:0]                 body_xor;
  logic [7:0]                 tail0;
  logic [7:0]                 tail1;
  logic [7:0]                 tail2;
  logic [15:0]                elapsed;
  logic [15:0]                elapsed_inc;

  logic [1:0]  eff_mode;
  logic        is_byte;
  logic        type_room;
  logic        body_room;
  logic [4:0]  hex_hi;
  logic [4:0]  hex_lo;
  logic [7:0]  got;
  logic [7:0]  chk;
  logic [2:0]  slots;
  logic [frp_pkg::TYPE_SLOTS-1:0] slot_hit;
  logic        any_hit;
  logic [frp_pkg::SLOT_W-1:0] first_slot;

  assign is_byte   = item_take && (command == frp_pkg::CMD_BYTE);
  assign eff_mode  = (mode != frp_pkg::MODE_IDLE && elapsed >= timeout_ticks) ?
                     frp_pkg::MODE_IDLE : mode;
  assign type_room = type_count < frp_pkg::TYPE_CW'(frp_pkg::TYPE_BYTES);
  assign body_room = body_count < frp_pkg::BODY_CW'(frp_pkg::BODY_BYTES);
  assign elapsed_inc = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_enable  <= 1'b1;
      timeout_ticks   <= frp_pkg::RESET_TIMEOUT;
      type_slots_used <= 3'd0;
      for (int i = 0; i < frp_pkg::TYPE_SLOTS; i++) begin
        type_pattern[i] <= 64'd0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        frp_pkg::REG_ENABLE:   receive_enable  <= cfg_data[0];
        frp_pkg::REG_TIMEOUT:  timeout_ticks   <= cfg_data[15:0];
        frp_pkg::REG_SLOTS:    type_slots_used <= cfg_data[2:0];
        frp_pkg::REG_PATTERN0: type_pattern[0] <= cfg_data;
        frp_pkg::REG_PATTERN1: type_pattern[1] <= cfg_data;
        frp_pkg::REG_PATTERN2: type_pattern[2] <= cfg_data;
        frp_pkg::REG_PATTERN3: type_pattern[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Checksum and hex field of the closing frame.
  always_comb begin
    hex_hi = frp_pkg::hex_digit(tail1);
    hex_lo = frp_pkg::hex_digit(tail0);
    got    = 8'd0;
    if (hex_hi[4]) begin
      got = hex_lo[4] ? {hex_hi[3:0], hex_lo[3:0]} : {4'd0, hex_hi[3:0]};
    end
    chk = type_xor ^ frp_pkg::CH_START ^ body_xor ^ tail0 ^ tail1 ^ tail2;
  end

  // Prefix match of the stored type against every slot.
  always_comb begin
    logic done;
    logic [7:0] pc;
    logic [7:0] tc;
    slots = (type_slots_used > 3'(frp_pkg::TYPE_SLOTS)) ?
            3'(frp_pkg::TYPE_SLOTS) : type_slots_used;
    for (int s = 0; s < frp_pkg::TYPE_SLOTS; s++) begin
      done = 1'b0;
      slot_hit[s] = 1'b1;
      for (int k = 0; k < 8; k++) begin
        pc = type_pattern[s][8*k +: 8];
        tc = (frp_pkg::TYPE_CW'(k) < type_count) ? type_store[k] : 8'd0;
        if (!done) begin
          if (pc == 8'd0) begin
            done = 1'b1;
          end else if (tc != pc) begin
            done = 1'b1;
            slot_hit[s] = 1'b0;
          end
        end
      end
      if (3'(s) >= slots) begin
        slot_hit[s] = 1'b0;
      end
    end
    any_hit = |slot_hit;
    first_slot = '0;
    for (int s = frp_pkg::TYPE_SLOTS - 1; s >= 0; s--) begin
      if (slot_hit[s]) begin
        first_slot = frp_pkg::SLOT_W'(s);
      end
    end
  end

  always_comb begin
    mode_next = mode;
    job = '0;
    ram_wr.en   = 1'b0;
    ram_wr.addr = body_count[frp_pkg::BODY_AW-1:0];
    ram_wr.data = rx_byte;
    if (item_take && command == frp_pkg::CMD_TICK) begin
      if (mode != frp_pkg::MODE_IDLE && elapsed_inc >= timeout_ticks) begin
        mode_next = frp_pkg::MODE_IDLE;
      end
    end else if (is_byte) begin
      unique case (eff_mode)
        frp_pkg::MODE_TYPE: begin
          mode_next = frp_pkg::MODE_TYPE;
          if (rx_byte == frp_pkg::CH_START) begin
            mode_next = frp_pkg::MODE_BODY;
          end else if (rx_byte == frp_pkg::CH_CR || rx_byte == frp_pkg::CH_LF) begin
            mode_next = frp_pkg::MODE_IDLE;
          end
        end
        frp_pkg::MODE_BODY: begin
          mode_next = frp_pkg::MODE_BODY;
          if (rx_byte == frp_pkg::CH_LF) begin
            mode_next = frp_pkg::MODE_IDLE;
            job.start = 1'b1;
            if (body_count < frp_pkg::BODY_CW'(3)) begin
              job.status = frp_pkg::ST_SHORT;
            end else if (chk != got) begin
              job.status = frp_pkg::ST_BAD_SUM;
            end else if (any_hit) begin
              job.status = frp_pkg::ST_ACCEPTED;
              job.slot   = first_slot;
              job.len    = frp_pkg::LEN_W'(body_count - frp_pkg::BODY_CW'(3));
            end else begin
              job.status = frp_pkg::ST_NO_TYPE;
            end
          end else if (rx_byte == frp_pkg::CH_START) begin
            mode_next = frp_pkg::MODE_IDLE;
          end else if (rx_byte != frp_pkg::CH_CR && body_room) begin
            ram_wr.en = 1'b1;
          end
        end
        default: begin
          mode_next = frp_pkg::MODE_IDLE;
          if (receive_enable && rx_byte == frp_pkg::CH_START) begin
            mode_next = frp_pkg::MODE_TYPE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= frp_pkg::MODE_IDLE;
      type_count <= '0;
      type_xor   <= 8'd0;
      type_ended <= 1'b0;
      body_count <= '0;
      body_xor   <= 8'd0;
      elapsed    <= 16'd0;
    end else begin
      mode <= mode_next;
      if (item_take && command == frp_pkg::CMD_TICK) begin
        if (mode != frp_pkg::MODE_IDLE) begin
          elapsed <= elapsed_inc;
        end
      end else if (is_byte) begin
        unique case (eff_mode)
          frp_pkg::MODE_TYPE: begin
            if (rx_byte != frp_pkg::CH_START && rx_byte != frp_pkg::CH_CR &&
                rx_byte != frp_pkg::CH_LF && type_room) begin
              type_count <= type_count + frp_pkg::TYPE_CW'(1);
              if (rx_byte == 8'd0) begin
                type_ended <= 1'b1;
              end else if (!type_ended) begin
                type_xor <= type_xor ^ rx_byte;
              end
            end
          end
          frp_pkg::MODE_BODY: begin
            if (ram_wr.en) begin
              body_count <= body_count + frp_pkg::BODY_CW'(1);
              body_xor   <= body_xor ^ rx_byte;
            end
          end
          default: begin
            if (receive_enable) begin
              elapsed <= 16'd0;
              if (rx_byte == frp_pkg::CH_START) begin
                type_count <= '0;
                type_xor   <= 8'd0;
                type_ended <= 1'b0;
                body_count <= '0;
                body_xor   <= 8'd0;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_byte && eff_mode == frp_pkg::MODE_TYPE && type_room &&
        rx_byte != frp_pkg::CH_START && rx_byte != frp_pkg::CH_CR &&
        rx_byte != frp_pkg::CH_LF) begin
      type_store[type_count[frp_pkg::TYPE_AW-1:0]] <= rx_byte;
    end
    if (ram_wr.en) begin
      tail2 <= tail1;
      tail1 <= tail0;
      tail0 <= rx_byte;
    end
  end

endmodule

### rtl/core/frp_emitter.sv
// Result sequencer: reads the body store and presents one result per transaction.
module frp_emitter (
  input  logic                         clk,
  input  logic                         rst,
  input  frp_pkg::job_t                job,
  input  logic [7:0]                   rd_data,
  output logic                         rd_en,
  output logic [frp_pkg::BODY_AW-1:0]  rd_addr,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   frame_status,
  output logic [1:0]                   matched_slot,
  output logic [5:0]                   body_length,
  output logic [7:0]                   body_byte,
  output logic                         byte_valid,
  output logic                         last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [1:0]                 state;
  logic [1:0]                 status;
  logic [frp_pkg::SLOT_W-1:0] slot;
  logic [frp_pkg::LEN_W-1:0]  len;
  logic [frp_pkg::BODY_AW-1:0] idx;
  logic                       has_data;
  logic                       at_end;

  assign at_end  = ({1'b0, idx} + 7'd1) == {1'b0, len};
  assign rd_en   = (state == S_READ);
  assign rd_addr = idx;
  assign busy    = (state != S_IDLE);

  assign out_valid    = (state == S_SHOW);
  assign frame_status = status;
  assign matched_slot = slot;
  assign body_length  = len;
  assign byte_valid   = has_data;
  assign body_byte    = has_data ? rd_data : 8'd0;
  assign last         = has_data ? at_end : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job.start) begin
            state <= (job.status == frp_pkg::ST_ACCEPTED && job.len != '0) ?
                     S_READ : S_SHOW;
          end
        end
        S_READ: state <= S_SHOW;
        S_SHOW: begin
          if (out_ready) begin
            state <= (has_data && !at_end) ? S_READ : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job.start) begin
      status   <= job.status;
      slot     <= job.slot;
      len      <= job.len;
      idx      <= '0;
      has_data <= (job.status == frp_pkg::ST_ACCEPTED && job.len != '0);
    end else if (state == S_SHOW && out_ready && has_data && !at_end) begin
      idx <= idx + frp_pkg::BODY_AW'(1);
    end
  end

endmodule

### rtl/core/framed_packet_receiver_core.sv
// Top level of the framed packet receiver: parser, body store and result sequencer.
// Each byte or tick transaction is taken while no results are pending.
// After a closing LF the first result shows next cycle, or after a store read for a body.
// Each body result is read from the body store only after the previous one is accepted.
// Input is not taken while results of a frame are being delivered.
// Synchronous reset puts the parser and result sequencer in idle and loads the default register values.
module framed_packet_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  frame_status,
  output logic [1:0]  matched_slot,
  output logic [5:0]  body_length,
  output logic [7:0]  body_byte,
  output logic        byte_valid,
  output logic        last
);

  frp_pkg::ram_wr_t             ram_wr;
  frp_pkg::job_t                job;
  logic                         rd_en;
  logic [frp_pkg::BODY_AW-1:0]  rd_addr;
  logic [7:0]                   rd_data;
  logic                         busy;

  assign in_ready = !busy;

  frp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_take (in_valid && in_ready),
    .command   (command),
    .rx_byte   (rx_byte),
    .ram_wr    (ram_wr),
    .job       (job)
  );

  frp_body_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  frp_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .rd_data      (rd_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_status (frame_status),
    .matched_slot (matched_slot),
    .body_length  (body_length),
    .body_byte    (body_byte),
    .byte_valid   (byte_valid),
    .last         (last)
  );

endmodule

### rtl/core/frp_checker.sv
// Port-level checker for the framed packet receiver, bound to the top level.
module frp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] frame_status,
  input logic [1:0] matched_slot,
  input logic [5:0] body_length,
  input logic [7:0] body_byte,
  input logic       byte_valid,
  input logic       last
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("Input taken while a result is pending.");

  a_data_only_accepted: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> frame_status == frp_pkg::ST_ACCEPTED && body_length != 6'd0)
    else $error("Body data on a frame that was not accepted.");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && body_length == 6'd0 && body_byte == 8'd0)
    else $error("A result without data must be the only one of its frame.");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status != frp_pkg::ST_ACCEPTED |-> matched_slot == 2'd0)
    else $error("Rejected frame reports a slot.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(body_byte) && $stable(last))
    else $error("Stalled result changed.");

endmodule

bind framed_packet_receiver_core frp_checker u_frp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_status (frame_status),
  .matched_slot (matched_slot),
  .body_length  (body_length),
  .body_byte    (body_byte),
  .byte_valid   (byte_valid),
  .last         (last)
);
